/* design/lzwe_pkg.sv */
// Package for the LZW encoder: constants, state and mode codes, controller/datapath structs.
`default_nettype none
package lzwe_pkg;

   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int CODE_WIDTH_DEF  = 12;
   localparam int FIRST_FREE_DEF  = 27;
   localparam int ALPHA_SIZE      = 256;

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0,
      MODE_DATA = 2'd1,
      MODE_EOS  = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_DECIDE,
      ST_RD,
      ST_CMP,
      ST_MISS,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;       // capture input item
      logic map_wr;      // write alphabet entry
      logic set_cur;     // first byte: current <= alphabet code
      logic scan_start;  // scan pointer <= first free code
      logic scan_next;   // scan pointer + 1
      logic cur_scan;    // hit: current <= scan pointer
      logic miss;        // add entry, emit current, restart string
      logic eos;         // pack final pair, clear string state
      logic shift;       // output byte taken
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      mode_type mode;
      logic     map_hit;
      logic     load_ok;
      logic     have_cur;
      logic     pend_valid;
      logic     scan_empty;
      logic     match;
      logic     scan_end;
      logic     byte_last;
   } stat_type;

endpackage
`default_nettype wire

/* design/lzw_encoder_12bit_packed_core.sv */
// Top level of the LZW encoder with packed fixed-width codes.
// Load item: IDLE, MAP, DECIDE; data byte: same, then RD, CMP per entry scanned, MISS on a miss.
// A miss that completes a pair, and every end of stream, then give 3 output items,
//   one per cycle while rsp_stall is low.
// Throughput: one item in flight; a new item is taken once the previous one is fully done.
// Reset (sync, active high): alphabet empty, string/pending cleared, next code = FIRST_FREE.
`default_nettype none
module lzw_encoder_12bit_packed_core #(
   parameter int TABLE_DEPTH = lzwe_pkg::TABLE_DEPTH_DEF,
   parameter int CODE_WIDTH  = lzwe_pkg::CODE_WIDTH_DEF,
   parameter int FIRST_FREE  = lzwe_pkg::FIRST_FREE_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_mode,
   input  wire logic [4:0] req_entry_index,
   input  wire logic [7:0] req_symbol,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last
);

   // command/status between the sequencer and the datapath
   lzwe_pkg::cmd_type  cmd;
   lzwe_pkg::stat_type stat;

   // sequencer: capture, map lookup, dictionary scan, miss/insert, byte output
   lzwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and arithmetic; output byte comes straight from the pack register
   lzwe_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CODE_WIDTH  (CODE_WIDTH),
      .FIRST_FREE  (FIRST_FREE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_symbol      (req_symbol),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // while results are offered no new item may be taken
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("item accepted during output");

   // an accepted item always closes the input side next cycle
   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("no stall after accept");

   // the final byte of a pair ends the output burst
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !rsp_stall) |=> !rsp_valid) else $error("burst overrun");

   // a pair never starts on its last byte
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !rsp_last) else $error("pair starts on last byte");
`endif

endmodule
`default_nettype wire

/* design/lzwe_ctrl.sv */
// Controller state machine of the LZW encoder.
`default_nettype none
module lzwe_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire lzwe_pkg::stat_type stat,
   output lzwe_pkg::cmd_type      cmd
);

   lzwe_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzwe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzwe_pkg::ST_IDLE: begin
            if (req_valid) state_in = lzwe_pkg::ST_MAP;
         end
         lzwe_pkg::ST_MAP: state_in = lzwe_pkg::ST_DECIDE;
         lzwe_pkg::ST_DECIDE: begin
            unique case (stat.mode)
               lzwe_pkg::MODE_DATA: begin
                  if (!stat.map_hit || !stat.have_cur) state_in = lzwe_pkg::ST_IDLE;
                  else if (stat.scan_empty)             state_in = lzwe_pkg::ST_MISS;
                  else                                  state_in = lzwe_pkg::ST_RD;
               end
               lzwe_pkg::MODE_EOS: state_in = lzwe_pkg::ST_OUT;
               default:            state_in = lzwe_pkg::ST_IDLE;
            endcase
         end
         lzwe_pkg::ST_RD: state_in = lzwe_pkg::ST_CMP;
         lzwe_pkg::ST_CMP: begin
            if (stat.match)         state_in = lzwe_pkg::ST_IDLE;
            else if (stat.scan_end) state_in = lzwe_pkg::ST_MISS;
            else                    state_in = lzwe_pkg::ST_RD;
         end
         lzwe_pkg::ST_MISS: begin
            state_in = stat.pend_valid ? lzwe_pkg::ST_OUT : lzwe_pkg::ST_IDLE;
         end
         lzwe_pkg::ST_OUT: begin
            if (!rsp_stall && stat.byte_last) state_in = lzwe_pkg::ST_IDLE;
         end
         default: state_in = lzwe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != lzwe_pkg::ST_IDLE);
      rsp_valid = (state_ff == lzwe_pkg::ST_OUT);
      unique case (state_ff)
         lzwe_pkg::ST_IDLE: cmd.latch = req_valid;
         lzwe_pkg::ST_DECIDE: begin
            unique case (stat.mode)
               lzwe_pkg::MODE_LOAD: cmd.map_wr = stat.load_ok;
               lzwe_pkg::MODE_DATA: begin
                  cmd.set_cur    = stat.map_hit && !stat.have_cur;
                  cmd.scan_start = stat.map_hit && stat.have_cur;
               end
               lzwe_pkg::MODE_EOS: cmd.eos = 1'b1;
               default: ;
            endcase
         end
         lzwe_pkg::ST_CMP: begin
            cmd.cur_scan  = stat.match;
            cmd.scan_next = !stat.match && !stat.scan_end;
         end
         lzwe_pkg::ST_MISS: cmd.miss  = 1'b1;
         lzwe_pkg::ST_OUT:  cmd.shift = !rsp_stall;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

/* design/lzwe_dp.sv */
// Datapath of the LZW encoder: alphabet map, dictionary memories, string and packing registers.
`default_nettype none
module lzwe_dp #(
   parameter int TABLE_DEPTH = lzwe_pkg::TABLE_DEPTH_DEF,
   parameter int CODE_WIDTH  = lzwe_pkg::CODE_WIDTH_DEF,
   parameter int FIRST_FREE  = lzwe_pkg::FIRST_FREE_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        req_mode,
   input  wire logic [4:0]        req_entry_index,
   input  wire logic [7:0]        req_symbol,
   input  wire lzwe_pkg::cmd_type cmd,
   output lzwe_pkg::stat_type     stat,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last
);

   localparam int AW         = $clog2(TABLE_DEPTH);
   localparam int MW         = (FIRST_FREE > 1) ? $clog2(FIRST_FREE) : 1;
   localparam int PAIR_BYTES = (2 * CODE_WIDTH + 7) / 8;
   localparam int PW         = PAIR_BYTES * 8;
   localparam int PAD        = PW - 2 * CODE_WIDTH;
   localparam int CW_CNT     = $clog2(PAIR_BYTES);

   lzwe_pkg::mode_type mode_ff;
   logic [4:0]         idx_ff;
   logic [7:0]         sym_ff;

   logic [MW-1:0]      map_mem [lzwe_pkg::ALPHA_SIZE];
   logic [lzwe_pkg::ALPHA_SIZE-1:0] map_vld_ff;
   logic [MW-1:0]      map_code_ff;
   logic               map_hit_ff;

   logic [AW-1:0]      pre_mem [TABLE_DEPTH];
   logic [7:0]         chr_mem [TABLE_DEPTH];
   logic [AW-1:0]      ent_pre_ff;
   logic [7:0]         ent_chr_ff;

   logic [AW-1:0]         cur_ff, next_ff, scan_ff;
   logic                  have_ff, pvld_ff;
   logic [CODE_WIDTH-1:0] pend_ff;
   logic [PW-1:0]         sh_ff;
   logic [CW_CNT-1:0]     cnt_ff;

   logic [8:0]            idx9, map9;
   logic [AW:0]           next_inc, scan_inc;
   logic [CODE_WIDTH-1:0] cur_cw;

   function automatic logic [PW-1:0] pack(input logic [CODE_WIDTH-1:0] a,
                                          input logic [CODE_WIDTH-1:0] b);
      logic [PW-1:0] w;
      w = PW'({a, b});
      return w << PAD;
   endfunction

   assign idx9     = 9'(idx_ff);
   assign map9     = 9'(map_code_ff);
   assign next_inc = (AW + 1)'(next_ff) + 1'b1;
   assign scan_inc = (AW + 1)'(scan_ff) + 1'b1;
   assign cur_cw   = CODE_WIDTH'(cur_ff);

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= lzwe_pkg::mode_type'(req_mode);
         idx_ff  <= req_entry_index;
         sym_ff  <= req_symbol;
      end
   end

   // alphabet map: registered read, present bits in flops
   always_ff @(posedge clock) begin
      map_code_ff <= map_mem[sym_ff];
      if (cmd.map_wr) map_mem[sym_ff] <= MW'(idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
         map_hit_ff <= 1'b0;
      end else begin
         map_hit_ff <= map_vld_ff[sym_ff];
         if (cmd.map_wr) map_vld_ff[sym_ff] <= 1'b1;
      end
   end

   // dictionary: registered read at the scan pointer, write at next code
   always_ff @(posedge clock) begin
      ent_pre_ff <= pre_mem[scan_ff];
      ent_chr_ff <= chr_mem[scan_ff];
      if (cmd.miss) begin
         pre_mem[next_ff] <= cur_ff;
         chr_mem[next_ff] <= sym_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start)     scan_ff <= AW'(FIRST_FREE);
      else if (cmd.scan_next) scan_ff <= scan_inc[AW-1:0];
   end

   // string / pending / table state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         have_ff <= 1'b0;
         pend_ff <= '0;
         pvld_ff <= 1'b0;
         next_ff <= AW'(FIRST_FREE);
      end else if (cmd.set_cur) begin
         cur_ff  <= AW'(map_code_ff);
         have_ff <= 1'b1;
      end else if (cmd.cur_scan) begin
         cur_ff <= scan_ff;
      end else if (cmd.miss) begin
         cur_ff <= AW'(map_code_ff);
         if (next_inc >= (AW + 1)'(TABLE_DEPTH)) next_ff <= AW'(FIRST_FREE);
         else                                    next_ff <= next_inc[AW-1:0];
         if (pvld_ff) begin
            pvld_ff <= 1'b0;
         end else begin
            pend_ff <= cur_cw;
            pvld_ff <= 1'b1;
         end
      end else if (cmd.eos) begin
         cur_ff  <= '0;
         have_ff <= 1'b0;
         pend_ff <= '0;
         pvld_ff <= 1'b0;
         next_ff <= AW'(FIRST_FREE);
      end
   end

   // output packer
   always_ff @(posedge clock) begin
      if (cmd.miss) begin
         sh_ff <= pack(pend_ff, cur_cw);
      end else if (cmd.eos) begin
         sh_ff <= pvld_ff ? pack(pend_ff, cur_cw) : pack(cur_cw, '0);
      end else if (cmd.shift) begin
         sh_ff <= sh_ff << 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.miss || cmd.eos) begin
         cnt_ff <= '0;
      end else if (cmd.shift) begin
         cnt_ff <= stat.byte_last ? '0 : cnt_ff + 1'b1;
      end
   end

   assign rsp_out_byte = sh_ff[PW-1 -: 8];
   assign rsp_last     = stat.byte_last;

   always_comb begin
      stat.mode       = mode_ff;
      stat.map_hit    = map_hit_ff;
      stat.load_ok    = (idx9 < 9'(FIRST_FREE)) && (!map_hit_ff || idx9 <= map9);
      stat.have_cur   = have_ff;
      stat.pend_valid = pvld_ff;
      stat.scan_empty = (next_ff == AW'(FIRST_FREE));
      stat.match      = (ent_pre_ff == cur_ff) && (ent_chr_ff == sym_ff);
      stat.scan_end   = (scan_inc == (AW + 1)'(next_ff));
      stat.byte_last  = (cnt_ff == CW_CNT'(PAIR_BYTES - 1));
   end

endmodule
`default_nettype wire
